// ===== design/tty_line_editor_echo_core_defines.svh =====
// ----------------------------------------------------------------------------
// tty_line_editor_echo_core_defines.svh
// Assertion macros shared by the line editor RTL.
// ----------------------------------------------------------------------------
`ifndef TTY_LINE_EDITOR_ECHO_CORE_DEFINES_SVH
`define TTY_LINE_EDITOR_ECHO_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define TLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define TLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// Constants and shared types of the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_MAX = 1024;
  localparam int FILL_W   = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int ECHO_MAX = 6;
  localparam int CNT_W    = 3;

  localparam logic [7:0] KEY_DEL      = 8'h7F;
  localparam logic [7:0] KEY_ETX      = 8'h03;
  localparam logic [7:0] KEY_CR       = 8'h0D;
  localparam logic [7:0] KEY_LF       = 8'h0A;
  localparam logic [7:0] KEY_BS       = 8'h08;
  localparam logic [7:0] KEY_SP       = 8'h20;
  localparam logic [7:0] KEY_CARET    = 8'h5E;
  localparam logic [7:0] CARET_OFFSET = 8'h40;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;

  localparam logic [1:0] END_LIMIT = 2'd0;
  localparam logic [1:0] END_ETX   = 2'd1;
  localparam logic [1:0] END_CR    = 2'd2;

  localparam logic CFG_MAX_LENGTH = 1'b0;
  localparam logic CFG_NO_ECHO    = 1'b1;

  // Everything the output side needs to play back one item's results.
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         ne;
    logic [ECHO_MAX-1:0][7:0] echo;
    logic                     stored;
    logic [FILL_W-1:0]        sidx;
    logic [7:0]               sbyte;
    logic                     done;
    logic [1:0]               kind;
    logic [LEN_W-1:0]         len;
  } tle_item_t;

  // Line state update caused by one item.
  typedef struct packed {
    logic              stored;
    logic              mark;
    logic [FILL_W-1:0] fill_next;
  } tle_upd_t;

endpackage

// ===== design/tty_line_editor_echo_core.sv =====
// ----------------------------------------------------------------------------
// tty_line_editor_echo_core
// Terminal line editor: stores received bytes, handles erase, echoes and
// reports the end of each line.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    char_in
//  out      out_valid/out_stall  echo_valid echo_byte store_* line_done
//                                line_length end_kind last
//  cfg      cfg_write            cfg_index cfg_data
//
// A byte is decoded and updates the line state in the cycle it is accepted.
// Its results (zero to six) leave one per cycle while out_stall is low; the
// next byte is taken in the cycle the final result enters the output
// register, and a byte with no results does not occupy the output slot.
// rst is synchronous; the mark memory needs no clearing because every
// position is written before it is read. A stalled output holds its beat.
// ----------------------------------------------------------------------------
`include "tty_line_editor_echo_core_defines.svh"

module tty_line_editor_echo_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [tle_pkg::LEN_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 char_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       echo_valid,
  output logic [7:0]                 echo_byte,
  output logic                       store_valid,
  output logic [tle_pkg::FILL_W-1:0] store_index,
  output logic [7:0]                 store_byte,
  output logic                       line_done,
  output logic [tle_pkg::LEN_W-1:0]  line_length,
  output logic [1:0]                 end_kind,
  output logic                       last
);
  import tle_pkg::*;

  logic [LEN_W-1:0]  max_length;
  logic              no_echo;
  logic              accept;
  logic              take;
  logic [FILL_W-1:0] fill;
  logic              mark_top;
  tle_item_t         item;
  tle_upd_t          upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= LEN_W'(LINE_MAX);
      no_echo    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_LENGTH: max_length <= cfg_data;
        CFG_NO_ECHO:    no_echo    <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign take   = accept && (item.count != '0);

  tle_line_state u_state (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .upd      (upd),
    .fill     (fill),
    .mark_top (mark_top)
  );

  tle_decode u_decode (
    .char_in    (char_in),
    .fill       (fill),
    .mark_top   (mark_top),
    .max_length (max_length),
    .no_echo    (no_echo),
    .item       (item),
    .upd        (upd)
  );

  tle_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .slot_stall  (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .echo_valid  (echo_valid),
    .echo_byte   (echo_byte),
    .store_valid (store_valid),
    .store_index (store_index),
    .store_byte  (store_byte),
    .line_done   (line_done),
    .line_length (line_length),
    .end_kind    (end_kind),
    .last        (last)
  );

  `TLE_ASSERT_NEXT(a_del_empty, accept && (fill == '0) && (char_in == KEY_DEL), fill == '0, "erase on empty line changed fill")
  `TLE_ASSERT_NOW(a_done_last, out_valid && line_done, last && (line_length != '0), "line end not on final beat")
  `TLE_ASSERT_NOW(a_plain_store, out_valid && !echo_valid, store_valid && last, "beat carries neither echo nor store")

endmodule

// ===== design/tle_line_state.sv =====
// ----------------------------------------------------------------------------
// tle_line_state
// Fill count of the current line and the per-position control-code marks.
// ----------------------------------------------------------------------------
module tle_line_state (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  tle_pkg::tle_upd_t        upd,
  output logic [tle_pkg::FILL_W-1:0] fill,
  output logic                     mark_top
);
  import tle_pkg::*;

  logic              marks [LINE_MAX];
  logic [FILL_W-1:0] rd_addr;

  // After an erase the new top of the line sits two below the old fill.
  assign rd_addr = fill - FILL_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= upd.fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && upd.stored) begin
      marks[fill] <= upd.mark;
    end
  end

  // While fill is nonzero, mark_top holds the mark of position fill-1.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (upd.stored) begin
        mark_top <= upd.mark;
      end else begin
        mark_top <= marks[rd_addr];
      end
    end
  end

endmodule

// ===== design/tle_decode.sv =====
// ----------------------------------------------------------------------------
// tle_decode
// Classifies one received byte and builds its result set and state update.
// ----------------------------------------------------------------------------
module tle_decode (
  input  logic [7:0]                 char_in,
  input  logic [tle_pkg::FILL_W-1:0] fill,
  input  logic                       mark_top,
  input  logic [tle_pkg::LEN_W-1:0]  max_length,
  input  logic                       no_echo,
  output tle_pkg::tle_item_t         item,
  output tle_pkg::tle_upd_t          upd
);
  import tle_pkg::*;

  logic             is_term;
  logic             is_ctrl;
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] fill1;
  logic [1:0]       npre;
  logic [7:0]       pre0;
  logic [7:0]       pre1;

  always_comb begin
    is_term = (char_in == KEY_ETX) || (char_in == KEY_CR);
    is_ctrl = (char_in < CTRL_LIMIT);
    fill1   = {1'b0, fill} + LEN_W'(1);
    if (max_length == '0) begin
      lim = LEN_W'(1);
    end else if (max_length > LEN_W'(LINE_MAX)) begin
      lim = LEN_W'(LINE_MAX);
    end else begin
      lim = max_length;
    end

    item          = '0;
    upd.stored    = 1'b0;
    upd.mark      = is_ctrl;
    upd.fill_next = fill;
    npre          = 2'd0;
    pre0          = 8'h00;
    pre1          = 8'h00;

    if (char_in == KEY_DEL) begin
      if (fill != '0) begin
        upd.fill_next = fill - FILL_W'(1);
        if (mark_top) begin
          item.echo = {KEY_BS, KEY_BS, KEY_SP, KEY_SP, KEY_BS, KEY_BS};
          item.ne   = CNT_W'(6);
        end else if (!no_echo) begin
          item.echo = {8'h00, 8'h00, 8'h00, KEY_BS, KEY_SP, KEY_BS};
          item.ne   = CNT_W'(3);
        end
      end
    end else begin
      upd.stored  = 1'b1;
      item.stored = 1'b1;
      item.sidx   = fill;
      item.sbyte  = char_in;
      if (is_term) begin
        item.done = 1'b1;
        item.kind = (char_in == KEY_ETX) ? END_ETX : END_CR;
      end else if (is_ctrl) begin
        npre = 2'd2;
        pre0 = KEY_CARET;
        pre1 = char_in + CARET_OFFSET;
      end else if (!no_echo) begin
        npre = 2'd1;
        pre0 = char_in;
      end
      if (!is_term && (fill1 >= lim)) begin
        item.done = 1'b1;
        item.kind = END_LIMIT;
      end
      item.echo[0] = pre0;
      item.echo[1] = pre1;
      item.ne      = CNT_W'(npre);
      if (item.done) begin
        item.echo[CNT_W'(npre)]         = KEY_CR;
        item.echo[CNT_W'(npre) + 3'd1] = KEY_LF;
        item.ne                         = CNT_W'(npre) + 3'd2;
        item.len                        = fill1;
        upd.fill_next                   = '0;
      end else begin
        upd.fill_next = fill1[FILL_W-1:0];
      end
    end

    // A stored byte with nothing to echo still yields one result.
    if (item.ne == '0 && item.stored) begin
      item.count = CNT_W'(1);
    end else begin
      item.count = item.ne;
    end
  end

endmodule

// ===== design/tle_emit.sv =====
// ----------------------------------------------------------------------------
// tle_emit
// Holds one decoded item and plays its results out through the output register.
// ----------------------------------------------------------------------------
module tle_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  tle_pkg::tle_item_t          item,
  output logic                        slot_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        echo_valid,
  output logic [7:0]                  echo_byte,
  output logic                        store_valid,
  output logic [tle_pkg::FILL_W-1:0]  store_index,
  output logic [7:0]                  store_byte,
  output logic                        line_done,
  output logic [tle_pkg::LEN_W-1:0]   line_length,
  output logic [1:0]                  end_kind,
  output logic                        last
);
  import tle_pkg::*;

  tle_item_t        desc;
  logic             desc_valid;
  logic [CNT_W-1:0] k;
  logic             adv;
  logic             is_last;
  logic             first;
  logic             has_echo;

  assign adv        = !out_valid || !out_stall;
  assign is_last    = (k == desc.count - CNT_W'(1));
  assign first      = (k == '0);
  assign has_echo   = (k < desc.ne);
  // The slot frees in the cycle its final result moves into the output register.
  assign slot_stall = desc_valid && !(adv && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      out_valid  <= 1'b0;
      k          <= '0;
    end else begin
      if (adv) begin
        out_valid <= desc_valid;
      end
      // A new item only arrives when the slot is empty or its final beat leaves.
      if (take) begin
        desc_valid <= 1'b1;
        k          <= '0;
      end else if (adv && desc_valid) begin
        if (is_last) begin
          desc_valid <= 1'b0;
          k          <= '0;
        end else begin
          k <= k + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc <= item;
    end
    if (adv && desc_valid) begin
      echo_valid  <= has_echo;
      echo_byte   <= has_echo ? desc.echo[k] : 8'h00;
      store_valid <= first && desc.stored;
      store_index <= (first && desc.stored) ? desc.sidx : '0;
      store_byte  <= (first && desc.stored) ? desc.sbyte : 8'h00;
      line_done   <= is_last && desc.done;
      line_length <= (is_last && desc.done) ? desc.len : '0;
      end_kind    <= (is_last && desc.done) ? desc.kind : END_LIMIT;
      last        <= is_last;
    end
  end

endmodule
